>>> src/fra_pkg.sv
// Shared types, field positions and sizes for the fragment reassembly block.
package fra_pkg;

  // Number of message contexts tracked at once (1 to 4).
  localparam int NUM_CONTEXTS = 4;
  localparam int CTX_W        = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

  // Packet word fields
  localparam int WORD_W  = 32;
  localparam int ID_W    = 2;
  localparam int CNT_W   = 3;
  localparam int SEQ_W   = 3;
  localparam int MODE_W  = 4;
  localparam int BYTES_W = 16;
  localparam int ERR_W   = 4;
  localparam int BYTE_W  = 8;

  localparam int ID_LSB    = 30;
  localparam int CNT_LSB   = 27;
  localparam int SEQ_LSB   = 24;
  localparam int MODE_LSB  = 20;
  localparam int BYTES_LSB = 4;
  localparam int ERR_LSB   = 0;

  // Fragment slots per context and fragment memory geometry
  localparam int SLOTS      = 1 << SEQ_W;
  localparam int FRAG_AW    = ID_W + SEQ_W;
  localparam int FRAG_DEPTH = 1 << FRAG_AW;

  // Fragment memory request from the sequencer
  typedef struct packed {
    logic               we;
    logic [FRAG_AW-1:0] waddr;
    logic [BYTES_W-1:0] wdata;
    logic               re;
    logic [FRAG_AW-1:0] raddr;
  } mem_req_t;

  // One result transaction
  typedef struct packed {
    logic [ID_W-1:0]   message_id;
    logic [MODE_W-1:0] access_mode;
    logic [BYTE_W-1:0] name_byte;
    logic              byte_valid;
    logic              last;
  } res_t;

endpackage

>>> src/fra_in_if.sv
// Packet input channel: valid/ready handshake carrying one packet word.
interface fra_in_if import fra_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] packet_word;

  modport source (output valid, output packet_word, input ready);
  modport sink   (input valid, input packet_word, output ready);
endinterface

>>> src/fra_out_if.sv
// Result output channel: valid/ready handshake carrying one name byte result.
interface fra_out_if import fra_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   message_id;
  logic [MODE_W-1:0] access_mode;
  logic [BYTE_W-1:0] name_byte;
  logic              byte_valid;
  logic              last;

  modport source (output valid, output message_id, output access_mode,
                  output name_byte, output byte_valid, output last, input ready);
  modport sink   (input valid, input message_id, input access_mode,
                  input name_byte, input byte_valid, input last, output ready);
endinterface

>>> src/fra_frag_mem.sv
// Fragment memory: one write port, one registered read port.
module fra_frag_mem import fra_pkg::*; (
  input  logic               clk,
  input  mem_req_t           req,
  output logic [BYTES_W-1:0] rdata
);

  logic [BYTES_W-1:0] mem [FRAG_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port, holds while not reading
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

>>> src/fra_ctrl.sv
// Context tracking and byte sequencer: stores fragments, detects completion,
// then walks the completed message one slot read and one byte at a time.
module fra_ctrl import fra_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [WORD_W-1:0]  packet_word,
  output mem_req_t           mem_req,
  input  logic [BYTES_W-1:0] mem_rdata,
  output logic               res_valid,
  input  logic               res_ready,
  output res_t               res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_HI   = 3'd2;
  localparam logic [2:0] S_LO   = 3'd3;
  localparam logic [2:0] S_END  = 3'd4;

  logic [2:0] state;

  // Per-context state
  logic              header_seen    [NUM_CONTEXTS];
  logic [CNT_W-1:0]  fragment_count [NUM_CONTEXTS];
  logic [MODE_W-1:0] mode_store     [NUM_CONTEXTS];
  logic [SLOTS-1:0]  present_mask   [NUM_CONTEXTS];

  // Message being emitted
  logic [ID_W-1:0]   cur_id;
  logic [CNT_W-1:0]  cur_cnt;
  logic [MODE_W-1:0] cur_mode;
  logic [SEQ_W-1:0]  slot;
  logic [BYTE_W-1:0] pend;
  logic              have_pend;

  // Field decode
  logic [ID_W-1:0]    f_id;
  logic [CNT_W-1:0]   f_cnt;
  logic [SEQ_W-1:0]   f_seq;
  logic [MODE_W-1:0]  f_mode;
  logic [BYTES_W-1:0] f_bytes;
  logic [ERR_W-1:0]   f_err;
  logic [CTX_W-1:0]   idx;

  assign f_id    = packet_word[ID_LSB +: ID_W];
  assign f_cnt   = packet_word[CNT_LSB +: CNT_W];
  assign f_seq   = packet_word[SEQ_LSB +: SEQ_W];
  assign f_mode  = packet_word[MODE_LSB +: MODE_W];
  assign f_bytes = packet_word[BYTES_LSB +: BYTES_W];
  assign f_err   = packet_word[ERR_LSB +: ERR_W];
  assign idx     = CTX_W'(f_id);

  logic accept, drop, is_header;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign drop      = (f_err != '0) || ({1'b0, f_id} >= (ID_W + 1)'(NUM_CONTEXTS));
  assign is_header = (f_seq == '0);

  // Context update as the packet lands, and completion check on the result
  logic              hdr_next;
  logic [CNT_W-1:0]  cnt_next;
  logic [MODE_W-1:0] mode_next;
  logic [SLOTS-1:0]  mask_next;
  logic [SLOTS-1:0]  need;
  logic              complete;

  always_comb begin
    hdr_next  = is_header || header_seen[idx];
    cnt_next  = is_header ? f_cnt : fragment_count[idx];
    mode_next = is_header ? f_mode : mode_store[idx];
    mask_next = (is_header ? '0 : present_mask[idx]) | (SLOTS'(1) << f_seq);
    need      = ~({SLOTS{1'b1}} << cnt_next);
    complete  = hdr_next && (cnt_next != '0) && ((mask_next & need) == need);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CONTEXTS; c++) begin
        header_seen[c]    <= 1'b0;
        fragment_count[c] <= '0;
        mode_store[c]     <= '0;
        present_mask[c]   <= '0;
      end
    end else if (accept && !drop) begin
      if (complete) begin
        header_seen[idx]    <= 1'b0;
        fragment_count[idx] <= '0;
        mode_store[idx]     <= '0;
        present_mask[idx]   <= '0;
      end else begin
        header_seen[idx]    <= hdr_next;
        fragment_count[idx] <= cnt_next;
        mode_store[idx]     <= mode_next;
        present_mask[idx]   <= mask_next;
      end
    end
  end

  // Memory requests: store on accept, slot read in S_RD
  always_comb begin
    mem_req.we    = accept && !drop;
    mem_req.waddr = {f_id, f_seq};
    mem_req.wdata = f_bytes;
    mem_req.re    = (state == S_RD);
    mem_req.raddr = {cur_id, slot};
  end

  // Byte under inspection and result formation; a byte is held back until
  // the following one shows whether it ends the name
  logic [BYTE_W-1:0] cur_byte;
  logic              byte_zero;
  logic              advance;

  always_comb begin
    cur_byte  = (state == S_HI) ? mem_rdata[BYTES_W-1 -: BYTE_W] : mem_rdata[BYTE_W-1:0];
    byte_zero = (cur_byte == '0);
    res_valid = 1'b0;
    unique case (state)
      S_HI, S_LO: res_valid = byte_zero || have_pend;
      S_END:      res_valid = 1'b1;
      default:    res_valid = 1'b0;
    endcase
    res.message_id  = cur_id;
    res.access_mode = cur_mode;
    res.name_byte   = have_pend ? pend : '0;
    res.byte_valid  = have_pend;
    res.last        = (state == S_END) || byte_zero;
    advance         = !res_valid || res_ready;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      have_pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && !drop && complete) begin
            state     <= S_RD;
            have_pend <= 1'b0;
          end
        end
        S_RD: begin
          state <= S_HI;
        end
        S_HI: begin
          if (advance) begin
            if (byte_zero) begin
              state <= S_IDLE;
            end else begin
              have_pend <= 1'b1;
              state     <= S_LO;
            end
          end
        end
        S_LO: begin
          if (advance) begin
            if (byte_zero) begin
              state <= S_IDLE;
            end else if (slot == cur_cnt - CNT_W'(1)) begin
              state <= S_END;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_END: begin
          if (advance) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Message payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && !drop && complete) begin
      cur_id   <= f_id;
      cur_cnt  <= cnt_next;
      cur_mode <= mode_next;
      slot     <= '0;
    end
    if ((state == S_HI || state == S_LO) && advance && !byte_zero) begin
      pend <= cur_byte;
    end
    if (state == S_LO && advance && !byte_zero) begin
      slot <= slot + SEQ_W'(1);
    end
  end

  // Assertions
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && res.last) |=> (state == S_IDLE))
    else $error("final result did not return the sequencer to idle");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.byte_valid) |-> res.last)
    else $error("empty-name result not marked last");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (slot < cur_cnt))
    else $error("slot read beyond fragment count");

  a_ctx_cleared: assert property (@(posedge clk) disable iff (rst)
    (accept && !drop && complete) |=>
      (!header_seen[CTX_W'(cur_id)] && present_mask[CTX_W'(cur_id)] == '0))
    else $error("completed context not cleared");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !mem_req.we)
    else $error("fragment written while emitting");

endmodule

>>> src/fragment_reassembly_by_id.sv
// Top level of the fragment reassembly block: sequencer, fragment memory, output register.
//
// Packets are taken one per cycle while the block is idle; a dropped or
// non-completing packet leaves the block idle. A packet that completes a message of
// cnt fragments holds input ready low while the sequencer walks the message
// through the single fragment memory read port, slot by slot (read, high
// byte, low byte), then releases the held final byte in a final state when
// the name runs to the end; a zero byte ends the walk early, and output
// stalls lengthen it. Results leave through a one-entry output register; the
// sequencer waits on a result while the register is full and not being
// taken. The fragment memory has no reset; only slots marked present are
// ever read.
module fragment_reassembly_by_id import fra_pkg::*; (
  input logic    clk,
  input logic    rst,
  fra_in_if.sink   packet,
  fra_out_if.source result
);

  mem_req_t           mem_req;
  logic [BYTES_W-1:0] mem_rdata;
  logic               res_valid;
  logic               res_ready;
  res_t               res;

  fra_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (packet.valid),
    .in_ready    (packet.ready),
    .packet_word (packet.packet_word),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  fra_frag_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // Output register
  logic obuf_valid;
  res_t obuf;

  assign res_ready = !obuf_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_valid <= 1'b0;
    end else if (res_ready) begin
      obuf_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      obuf <= res;
    end
  end

  assign result.valid       = obuf_valid;
  assign result.message_id  = obuf.message_id;
  assign result.access_mode = obuf.access_mode;
  assign result.name_byte   = obuf.name_byte;
  assign result.byte_valid  = obuf.byte_valid;
  assign result.last        = obuf.last;

endmodule
